FILE: rtl/rbd_pkg.sv
// rbd_pkg: shared types and constants for the run-length byte decoder.
// Used by every module in rtl/; depends on nothing.
package rbd_pkg;

	localparam int LANE_BYTES_DEF   = 8;
	localparam int CAPACITY_MAX_DEF = 65535;
	localparam int CMD_DEPTH        = 2;

	localparam logic [7:0]  RUN_MARKER_RST      = 8'd255;
	localparam logic [7:0]  LITERAL_MARKER_RST  = 8'd254;
	localparam logic [7:0]  MIN_RUN_RST         = 8'd3;
	localparam logic [15:0] OUTPUT_CAPACITY_RST = 16'd4096;

	typedef enum logic [1:0] {
		REG_RUN_MARKER      = 2'd0,
		REG_LITERAL_MARKER  = 2'd1,
		REG_MIN_RUN         = 2'd2,
		REG_OUTPUT_CAPACITY = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic [7:0]  run_marker;
		logic [7:0]  literal_marker;
		logic [7:0]  min_run;
		logic [15:0] output_capacity;
	} cfg_t;

	// One command: len copies of value, then an end word when last is set.
	typedef struct packed {
		logic [7:0]  value;
		logic [7:0]  len;
		logic        last;
		logic [15:0] total;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_stat_t;

endpackage

FILE: rtl/rbd_ifs.sv
// rbd_ifs: valid/ready channel interfaces for the decoder's input and output.
// Standalone; no package needed.
interface rbd_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  in_byte;
	logic [15:0] bytes_left;

	modport source (output valid, output in_byte, output bytes_left, input ready);
	modport sink (input valid, input in_byte, input bytes_left, output ready);
endinterface

interface rbd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_data;
	logic [3:0]  byte_count;
	logic        end_of_block;
	logic [15:0] total_length;

	modport source (output valid, output out_data, output byte_count,
		output end_of_block, output total_length, input ready);
	modport sink (input valid, input out_data, input byte_count,
		input end_of_block, input total_length, output ready);
endinterface

FILE: rtl/rbd_front.sv
// rbd_front: token parser. Classifies each input byte, tracks the token state
// and capacity, and pushes run/literal/end commands. Uses rbd_pkg.
module rbd_front
	import rbd_pkg::*;
#(
	parameter int CAPACITY_MAX = CAPACITY_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_fire,
	input  logic [7:0]  in_byte,
	input  logic [15:0] bytes_left,
	output logic        push,
	output cmd_t        cmd
);

	typedef enum logic [3:0] {
		PH_IDLE      = 4'b0001,
		PH_RUN_COUNT = 4'b0010,
		PH_RUN_VALUE = 4'b0100,
		PH_LIT_COUNT = 4'b1000
	} phase_t;

	localparam logic [15:0] CapMax = 16'(CAPACITY_MAX);

	phase_t      phase_q, phase_d;
	logic [7:0]  run_len_q, run_len_d;
	logic [7:0]  lit_rem_q, lit_rem_d;
	logic [15:0] wt_q, wt_d;
	logic        halted_q, halted_d;

	logic [15:0] cap;
	logic [16:0] sum_run, sum_one, sum_lit;
	logic [7:0]  lit_cnt, lit_cut;
	logic [7:0]  out_len;
	logic        last;

	always_comb begin
		cap     = (cfg.output_capacity > CapMax) ? CapMax : cfg.output_capacity;
		lit_cnt = in_byte + 8'd1;
		lit_cut = ({8'd0, lit_cnt} > bytes_left) ? bytes_left[7:0] : lit_cnt;
		sum_run = {1'b0, wt_q} + {9'd0, run_len_q};
		sum_one = {1'b0, wt_q} + 17'd1;
		sum_lit = {1'b0, wt_q} + {9'd0, lit_cut};
		last    = (bytes_left == 16'd0);

		phase_d   = phase_q;
		run_len_d = run_len_q;
		lit_rem_d = lit_rem_q;
		wt_d      = wt_q;
		halted_d  = halted_q;
		out_len   = 8'd0;

		if (!halted_q) begin
			unique case (phase_q)
				PH_RUN_COUNT: begin
					run_len_d = in_byte + cfg.min_run;
					phase_d   = PH_RUN_VALUE;
				end
				PH_RUN_VALUE: begin
					phase_d = PH_IDLE;
					if (sum_run > {1'b0, cap}) begin
						halted_d = 1'b1;
					end else begin
						out_len = run_len_q;
						wt_d    = sum_run[15:0];
					end
				end
				PH_LIT_COUNT: begin
					phase_d = PH_IDLE;
					if (sum_lit > {1'b0, cap}) begin
						halted_d = 1'b1;
					end else begin
						lit_rem_d = lit_cut;
					end
				end
				default: begin
					priority if (lit_rem_q != 8'd0) begin
						if (sum_one > {1'b0, cap}) begin
							halted_d = 1'b1;
						end else begin
							out_len   = 8'd1;
							wt_d      = sum_one[15:0];
							lit_rem_d = lit_rem_q - 8'd1;
						end
					end else if (in_byte == cfg.run_marker && bytes_left >= 16'd2) begin
						phase_d = PH_RUN_COUNT;
					end else if (in_byte == cfg.literal_marker && bytes_left >= 16'd1) begin
						phase_d = PH_LIT_COUNT;
					end else if (sum_one > {1'b0, cap}) begin
						halted_d = 1'b1;
					end else begin
						out_len = 8'd1;
						wt_d    = sum_one[15:0];
					end
				end
			endcase
		end

		cmd.value = in_byte;
		cmd.len   = out_len;
		cmd.last  = last;
		cmd.total = wt_d;
		push      = in_fire && (out_len != 8'd0 || last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			run_len_q <= '0;
			lit_rem_q <= '0;
			wt_q      <= '0;
			halted_q  <= 1'b0;
		end else if (in_fire) begin
			if (last) begin
				phase_q   <= PH_IDLE;
				run_len_q <= '0;
				lit_rem_q <= '0;
				wt_q      <= '0;
				halted_q  <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				run_len_q <= run_len_d;
				lit_rem_q <= lit_rem_d;
				wt_q      <= wt_d;
				halted_q  <= halted_d;
			end
		end
	end

endmodule

FILE: rtl/rbd_cmd_fifo.sv
// rbd_cmd_fifo: short command queue between parser and expander.
// Uses rbd_pkg for cmd_t and q_stat_t.
module rbd_cmd_fifo
	import rbd_pkg::*;
#(
	parameter int DEPTH = CMD_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    wr_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t stat
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

	cmd_t            entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign head           = entry_q[rd_ptr_q];
	assign stat.full      = (count_q == DepthC);
	assign stat.not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/rbd_back.sv
// rbd_back: expander. Turns commands into packed output words and end words,
// held in an output register. Uses rbd_pkg and rbd_out_if.
module rbd_back
	import rbd_pkg::*;
#(
	parameter int LANE_BYTES = LANE_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      head,
	input  q_stat_t   stat,
	output logic      pop,
	rbd_out_if.source out_ch
);

	localparam logic [7:0] LaneC = 8'(LANE_BYTES);

	cmd_t        hold_q;
	logic        loaded_q;
	logic        out_valid_q;
	logic [63:0] data_q;
	logic [3:0]  count_q;
	logic        eob_q;
	logic [15:0] total_q;

	cmd_t        cur;
	cmd_t        nxt;
	logic        cur_valid, slot_free, fire, is_data, done;
	logic [7:0]  take;
	logic [63:0] data_d;

	always_comb begin
		cur       = loaded_q ? hold_q : head;
		cur_valid = loaded_q || stat.not_empty;
		slot_free = !out_valid_q || out_ch.ready;
		fire      = slot_free && cur_valid;
		pop       = fire && !loaded_q;
		is_data   = (cur.len != 8'd0);
		take      = (cur.len > LaneC) ? LaneC : cur.len;
		done      = is_data ? (cur.len == take && !cur.last) : 1'b1;
		nxt       = cur;
		nxt.len   = cur.len - take;
		data_d    = '0;
		for (int i = 0; i < LANE_BYTES; i++) begin
			if (8'(i) < take) begin
				data_d[8*i +: 8] = cur.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (fire) begin
			loaded_q    <= !done;
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hold_q  <= nxt;
			data_q  <= data_d;
			count_q <= 4'(take);
			eob_q   <= !is_data;
			total_q <= is_data ? 16'd0 : cur.total;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_data     = data_q;
	assign out_ch.byte_count   = count_q;
	assign out_ch.end_of_block = eob_q;
	assign out_ch.total_length = total_q;

endmodule

FILE: rtl/rle_byte_decoder.sv
// rle_byte_decoder: marker-based run-length byte stream decoder, top level.
// A word passes the queue reg, then the output reg, after its input byte is accepted.
// Throughput: 1 input byte per cycle for plain and literal bytes while the queue is not full;
// a run of L bytes becomes ceil(L/LANE_BYTES) output words, plus an end word at block end.
// Reset: arst_n clears token state, queue and output valid; config regs go to defaults.
module rle_byte_decoder
	import rbd_pkg::*;
#(
	parameter int LANE_BYTES   = LANE_BYTES_DEF,
	parameter int CAPACITY_MAX = CAPACITY_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rbd_in_if.sink      in_ch,
	rbd_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	// Configuration registers; user must write only while the decoder is idle (block does not enforce).
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.run_marker      <= RUN_MARKER_RST;
			cfg_q.literal_marker  <= LITERAL_MARKER_RST;
			cfg_q.min_run         <= MIN_RUN_RST;
			cfg_q.output_capacity <= OUTPUT_CAPACITY_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_RUN_MARKER:      cfg_q.run_marker      <= cfg_wdata[7:0];
				REG_LITERAL_MARKER:  cfg_q.literal_marker  <= cfg_wdata[7:0];
				REG_MIN_RUN:         cfg_q.min_run         <= cfg_wdata[7:0];
				REG_OUTPUT_CAPACITY: cfg_q.output_capacity <= cfg_wdata;
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	// Front: parses one byte per accepted word, stalls only on a full queue.
	logic    in_fire;
	logic    push, pop;
	cmd_t    push_cmd, head;
	q_stat_t q_stat;

	assign in_ch.ready = !q_stat.full;
	assign in_fire     = in_ch.valid && in_ch.ready;

	rbd_front #(
		.CAPACITY_MAX(CAPACITY_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_fire   (in_fire),
		.in_byte   (in_ch.in_byte),
		.bytes_left(in_ch.bytes_left),
		.push      (push),
		.cmd       (push_cmd)
	);

	// Command queue decouples parsing from run expansion.
	rbd_cmd_fifo #(
		.DEPTH(CMD_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_cmd(push_cmd),
		.pop   (pop),
		.head  (head),
		.stat  (q_stat)
	);

	// Back: expands commands into packed words behind an output register.
	rbd_back #(
		.LANE_BYTES(LANE_BYTES)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.stat  (q_stat),
		.pop   (pop),
		.out_ch(out_ch)
	);

endmodule

FILE: verif/rbd_tb_pkg.sv
// rbd_tb_pkg: scoreboard for the run-length byte decoder, with its own decode model
// and the queue of decoded words still due. Depends on rbd_pkg for the register indexes.
package rbd_tb_pkg;
	import rbd_pkg::*;

	typedef enum logic [1:0] {
		TP_IDLE      = 2'd0,
		TP_RUN_COUNT = 2'd1,
		TP_RUN_VALUE = 2'd2,
		TP_LIT_COUNT = 2'd3
	} token_phase_t;

	typedef struct {
		logic [63:0] data;
		logic [3:0]  count;
		logic        eob;
		logic [15:0] total;
	} out_word_t;

	localparam int LANE = 8;

	class rbd_scoreboard;
		logic [7:0]   run_marker;
		logic [7:0]   literal_marker;
		logic [7:0]   min_run;
		logic [15:0]  capacity;

		token_phase_t phase;
		logic [7:0]   run_len;
		logic [7:0]   lit_left;
		logic [15:0]  written;
		bit           halted;

		out_word_t    pending[$];
		int           errors;

		function new();
			run_marker     = RUN_MARKER_RST;
			literal_marker = LITERAL_MARKER_RST;
			min_run        = MIN_RUN_RST;
			capacity       = OUTPUT_CAPACITY_RST;
			errors         = 0;
			clear_block();
		endfunction

		function void clear_block();
			phase    = TP_IDLE;
			run_len  = '0;
			lit_left = '0;
			written  = '0;
			halted   = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [15:0] val);
			case (idx)
				REG_RUN_MARKER:      run_marker = val[7:0];
				REG_LITERAL_MARKER:  literal_marker = val[7:0];
				REG_MIN_RUN:         min_run = val[7:0];
				REG_OUTPUT_CAPACITY: capacity = val;
				default: ;
			endcase
		endfunction

		// Decode one accepted byte and queue the words it produces.
		function void note_input(logic [7:0] b, logic [15:0] left);
			logic [7:0] bytes_out[$];
			out_word_t  w;
			int         wt;
			int         cnt;
			int         i;
			wt = written;
			if (!halted) begin
				case (phase)
					TP_RUN_COUNT: begin
						run_len = b + min_run;
						phase = TP_RUN_VALUE;
					end
					TP_RUN_VALUE: begin
						phase = TP_IDLE;
						if (wt + run_len > capacity) begin
							halted = 1;
						end else begin
							repeat (run_len) bytes_out.push_back(b);
							wt += run_len;
						end
					end
					TP_LIT_COUNT: begin
						cnt = (int'(b) + 1) & 255;
						phase = TP_IDLE;
						if (cnt > int'(left))
							cnt = int'(left);
						if (wt + cnt > capacity)
							halted = 1;
						else
							lit_left = cnt[7:0];
					end
					default: begin
						if (lit_left > 0) begin
							if (wt + 1 > capacity) begin
								halted = 1;
							end else begin
								bytes_out.push_back(b);
								wt++;
								lit_left--;
							end
						end else if (b == run_marker && left >= 2) begin
							phase = TP_RUN_COUNT;
						end else if (b == literal_marker && left >= 1) begin
							phase = TP_LIT_COUNT;
						end else if (wt + 1 > capacity) begin
							halted = 1;
						end else begin
							bytes_out.push_back(b);
							wt++;
						end
					end
				endcase
			end
			written = wt[15:0];

			// pack into lanes, first byte lowest
			i = 0;
			while (i < bytes_out.size()) begin
				w.data  = '0;
				w.count = '0;
				w.eob   = 0;
				w.total = '0;
				while (i < bytes_out.size() && w.count < LANE) begin
					w.data = w.data | (64'(bytes_out[i]) << (8 * w.count));
					w.count++;
					i++;
				end
				pending.push_back(w);
			end

			if (left == 0) begin
				w.data  = '0;
				w.count = '0;
				w.eob   = 1;
				w.total = written;
				pending.push_back(w);
				clear_block();
			end
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_word(logic [63:0] data, logic [3:0] count, logic eob, logic [15:0] total);
			out_word_t w;
			if (pending.size() == 0) begin
				report($sformatf("unexpected word data=%h count=%0d eob=%b total=%0d",
					data, count, eob, total));
				return;
			end
			w = pending.pop_front();
			if (data !== w.data)
				report($sformatf("out_data %h, want %h", data, w.data));
			if (count !== w.count)
				report($sformatf("byte_count %0d, want %0d", count, w.count));
			if (eob !== w.eob)
				report($sformatf("end_of_block %b, want %b", eob, w.eob));
			if (total !== w.total)
				report($sformatf("total_length %0d, want %0d", total, w.total));
		endtask
	endclass

endpackage

FILE: verif/tb_top.sv
// tb_top: self-checking bench for rle_byte_decoder; drives byte blocks with random
// gaps and output stalls, checks every word against the scoreboard in rbd_tb_pkg.
// Needs rbd_pkg, rbd_ifs and the decoder RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rbd_pkg::*;
	import rbd_tb_pkg::*;

	// The limit sits well above the slowest legal run (33 words per byte, an output
	// stall on each), leaving plenty of room on top.
	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEMS_PER_PHASE = 45;
	localparam int NUM_PHASES = 6;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	rbd_in_if  in_ch();
	rbd_out_if out_ch();

	rbd_scoreboard sb;
	bit            idling;
	int            cycles = 0;
	int            sent = 0;

	always #2 clk = ~clk;

	rle_byte_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Hard stop in case the decoder hangs or drops words.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Output side: check every accepted word, throttle ready in random bursts.
	// Valid and ready are sampled at the edge before any NBA of this step lands.
	initial begin : out_side
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_word(out_ch.out_data, out_ch.byte_count,
					out_ch.end_of_block, out_ch.total_length);
			if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 11);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Present one byte and hold it until the decoder takes it. Entered and left
	// on a rising edge; valid stays high on return, so the caller either sends
	// the next byte or lowers valid in that same step.
	task automatic send_byte(input logic [7:0] b, input logic [15:0] left);
		if (idling && $urandom_range(0, 6) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.in_byte    <= b;
		in_ch.bytes_left <= left;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(b, left);
		sent++;
	endtask

	// Stop sending and let the decoder run dry. Bytes such as markers make no
	// word, so the task waits on after the last word to cover its 2-stage pipe.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_config(input logic [7:0] rm, input logic [7:0] lm,
			input logic [7:0] mr, input logic [15:0] cap);
		write_reg(REG_RUN_MARKER, 16'(rm));
		write_reg(REG_LITERAL_MARKER, 16'(lm));
		write_reg(REG_MIN_RUN, 16'(mr));
		write_reg(REG_OUTPUT_CAPACITY, cap);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Build one block of well-formed tokens under the current markers: plain
	// bytes, runs (short mostly, now and then up to 255), literals.
	task automatic gen_block(input int n_tok, inout logic [7:0] blk[$]);
		int kind;
		int len;
		blk.delete();
		repeat (n_tok) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				blk.push_back(8'($urandom_range(0, 255)));
			end else if (kind < 7) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 20);
				blk.push_back(sb.run_marker);
				blk.push_back(8'(len - int'(sb.min_run)));
				blk.push_back(8'($urandom_range(0, 255)));
			end else begin
				len = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 255)
					: $urandom_range(0, 10);
				blk.push_back(sb.literal_marker);
				blk.push_back(8'(len));
				repeat ((len + 1) & 255) blk.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// bytes_left counts down to zero; a noisy block lies about it on some
	// bytes (never on the last one, so the block still closes where planned).
	task automatic send_block(input logic [7:0] blk[$], input bit noisy);
		int n;
		logic [15:0] left;
		n = blk.size();
		for (int i = 0; i < n; i++) begin
			left = 16'(n - 1 - i);
			if (noisy && left != 0 && $urandom_range(0, 3) == 0)
				left = 16'($urandom_range(1, 65535));
			send_byte(blk[i], left);
		end
	endtask

	initial begin : main
		logic [7:0]  blk[$];
		logic [7:0]  ph_rm[NUM_PHASES];
		logic [7:0]  ph_lm[NUM_PHASES];
		logic [7:0]  ph_mr[NUM_PHASES];
		logic [15:0] ph_cap[NUM_PHASES];
		int          start;
		int          pick;
		int          cut;

		sb = new();
		idling = 1;
		cfg_we = 1'b0;
		cfg_index = REG_RUN_MARKER;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		in_ch.bytes_left = '0;
		out_ch.ready = 1'b0;

		// Phase settings: full capacity, tight capacity with min_run 0,
		// identical markers with min_run 255, odd values, near-zero capacity,
		// and back to defaults for the final stretch without idling.
		ph_rm  = '{8'hFF, 8'h00, 8'h80, 8'h5A, 8'h7F, RUN_MARKER_RST};
		ph_lm  = '{8'hFE, 8'h01, 8'h80, 8'hA5, 8'hFF, LITERAL_MARKER_RST};
		ph_mr  = '{8'd3, 8'd0, 8'd255, 8'h10, 8'd1, MIN_RUN_RST};
		ph_cap = '{16'hFFFF, 16'd40, 16'd1000, 16'd300, 16'd2, OUTPUT_CAPACITY_RST};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- Directed part, reset settings (run FF, literal FE, min_run 3) ----
		// plain byte, run of 3, literal marker whose count is cut to zero by
		// the block end
		send_byte(8'h00, 16'd5);
		send_byte(8'hFF, 16'd4);
		send_byte(8'h00, 16'd3);
		send_byte(8'hAB, 16'd2);
		send_byte(8'hFE, 16'd1);
		send_byte(8'h05, 16'd0);
		// markers too close to the end pass through as plain bytes
		send_byte(8'hFF, 16'd1);
		send_byte(8'hFE, 16'd0);
		// zero-length run (bytes_left overstated on the marker), zero literal
		send_byte(8'hFF, 16'hFFFF);
		send_byte(8'hFD, 16'd4);
		send_byte(8'h11, 16'd3);
		send_byte(8'hFE, 16'd2);
		send_byte(8'hFF, 16'd1);
		send_byte(8'h7F, 16'd0);
		// longest run: 255 copies, 32 words plus the end word
		send_byte(8'hFF, 16'd2);
		send_byte(8'hFC, 16'd1);
		send_byte(8'h5A, 16'd0);
		// run left unfinished when the block closes
		send_byte(8'hFF, 16'd5);
		send_byte(8'h00, 16'd0);
		// literal of 3 (cut from 4), then capacity drops to 1 mid-literal
		send_byte(8'hFE, 16'd4);
		send_byte(8'h03, 16'd3);
		send_byte(8'h01, 16'd2);
		drain();
		apply_config(8'hFF, 8'hFE, 8'd3, 16'd1);
		send_byte(8'h02, 16'd1);
		send_byte(8'h03, 16'd0);
		// zero capacity halts on the first byte
		drain();
		apply_config(8'hFF, 8'hFE, 8'd3, 16'd0);
		send_byte(8'h44, 16'd0);

		// ---- Random part: one config per phase, written while drained ----
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			apply_config(ph_rm[ph], ph_lm[ph], ph_mr[ph], ph_cap[ph]);
			idling = (ph != NUM_PHASES - 1);
			start = sent;
			while (sent - start < ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					// junk: random bytes, no token structure
					blk.delete();
					repeat ($urandom_range(1, 6)) blk.push_back(8'($urandom_range(0, 255)));
				end else begin
					gen_block($urandom_range(1, 8), blk);
					if (pick == 1) begin
						// broken tail: the block closes mid-token
						cut = $urandom_range(1, blk.size());
						while (blk.size() > cut) void'(blk.pop_back());
					end
				end
				send_block(blk, pick == 2);
			end
		end

		// ---- Wrap-up ----
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
